[rtl/core/scta_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table of the sine/cosine angle converter.
package scta_pkg;

  localparam int SAMPLE_BITS  = 14;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;

  localparam int FRAC_SHIFT = 16;                    // 65536 scale of the span mapping
  localparam int NUM_W      = SAMPLE_BITS + FRAC_SHIFT + 1;
  localparam int M_W        = SAMPLE_BITS + 1;       // divisor 2*(high-low)
  localparam int Q_BITS     = 16;
  localparam int V_W        = 16;                    // Q2.14
  localparam int V_MAX_I    = 2 ** (V_W - 1) - 1;
  localparam int V_MIN_I    = -(2 ** (V_W - 1));
  localparam int ONE_Q14    = 16384;

  localparam int RAD_W  = 2 * V_W;
  localparam int ROOT_W = RAD_W / 2;
  localparam int NSTEP  = (CORDIC_STEPS > ROOT_W) ? CORDIC_STEPS : ROOT_W;

  localparam int CW         = 36;
  localparam int ZW         = 33;
  localparam int ANG_FRAC   = 16;
  localparam int ANG_W      = 17;
  localparam int OFS_W      = 17;
  localparam int TOL_W      = 15;
  localparam int ANGLE_W    = 16;
  localparam int MAG_W      = 16;
  localparam int WRAP_W     = 18;
  localparam int FULL_TURN  = 36000;
  localparam int WRAP_BIAS  = 3 * FULL_TURN;
  localparam int ROUND_HALF = 2 ** (ANG_FRAC - 1);
  localparam logic signed [ZW-1:0] QUARTER_TURN = 33'sd589824000;

  localparam logic signed [ZW-1:0] ATAN_TABLE [TABLE_LEN] = '{
    33'sd294912000, 33'sd174096719, 33'sd91987925, 33'sd46694507, 33'sd23437865,
    33'sd11730358, 33'sd5866610, 33'sd2933484, 33'sd1466764, 33'sd733385,
    33'sd366693, 33'sd183346, 33'sd91673, 33'sd45837, 33'sd22918,
    33'sd11459, 33'sd5730, 33'sd2865, 33'sd1432, 33'sd716,
    33'sd358, 33'sd179, 33'sd90, 33'sd45
  };

  localparam int Q_DEPTH = 4;
  localparam int QIDX_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = QIDX_W + 1;

  localparam int ADDR_W = 5;
  localparam int IDX_W  = ADDR_W - 2;
  localparam logic [IDX_W-1:0] REG_SINE_LOW   = 3'd0;
  localparam logic [IDX_W-1:0] REG_SINE_HIGH  = 3'd1;
  localparam logic [IDX_W-1:0] REG_COS_LOW    = 3'd2;
  localparam logic [IDX_W-1:0] REG_COS_HIGH   = 3'd3;
  localparam logic [IDX_W-1:0] REG_OFFSET     = 3'd4;
  localparam logic [IDX_W-1:0] REG_TOLERANCE  = 3'd5;

  localparam logic [SAMPLE_BITS-1:0] HIGH_RST = 14'd4095;
  localparam logic [TOL_W-1:0]       TOL_RST  = 15'd3277;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]  sine_low;
    logic [SAMPLE_BITS-1:0]  sine_high;
    logic [SAMPLE_BITS-1:0]  cosine_low;
    logic [SAMPLE_BITS-1:0]  cosine_high;
    logic signed [OFS_W-1:0] angle_offset;
    logic [TOL_W-1:0]        tolerance;
  } cfg_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [M_W-1:0]   div;
    logic             neg;
    logic             sat;
    logic             bad;
  } chan_t;

  typedef struct packed {
    chan_t sine;
    chan_t cosine;
  } item_t;

  typedef struct packed {
    logic signed [V_W-1:0] vs;
    logic signed [V_W-1:0] vc;
    logic                  bad;
  } mapped_t;

endpackage

[rtl/core/scta_front.sv]
`timescale 1ns / 1ps
// Front end: takes a sample pair and sets up the span division for each channel.
module scta_front import scta_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] sine_sample,
  input  logic [SAMPLE_BITS-1:0] cosine_sample,
  input  cfg_t                   cfg,
  input  logic [QCNT_W-1:0]      q_count,
  output logic                   busy,
  output logic                   push,
  output item_t                  push_item
);

  logic  fv;
  item_t item;

  // numerator of floor(((x-low)*65536 + d) / 2d), folded to a magnitude
  function automatic chan_t classify(input logic [SAMPLE_BITS-1:0] x,
                                     input logic [SAMPLE_BITS-1:0] lo,
                                     input logic [SAMPLE_BITS-1:0] hi);
    logic [SAMPLE_BITS-1:0] mag_a;
    logic [SAMPLE_BITS-1:0] d;
    chan_t                  c;
    c.neg = x < lo;
    mag_a = c.neg ? lo - x : x - lo;
    d     = hi - lo;
    c.bad = hi <= lo;
    c.div = {d, 1'b0};
    c.num = {1'b0, mag_a, {FRAC_SHIFT{1'b0}}} + NUM_W'(d) - NUM_W'(c.neg);
    c.sat = c.num >= {c.div, {Q_BITS{1'b0}}};
    return c;
  endfunction

  assign busy = ({1'b0, q_count} + {{QCNT_W{1'b0}}, fv}) >= (QCNT_W + 1)'(Q_DEPTH);
  assign push = fv;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else begin
      fv <= start && !busy;
    end
    if (start && !busy) begin
      item.sine   <= classify(sine_sample, cfg.sine_low, cfg.sine_high);
      item.cosine <= classify(cosine_sample, cfg.cosine_low, cfg.cosine_high);
    end
  end

endmodule

[rtl/core/scta_queue.sv]
`timescale 1ns / 1ps
// Short beat queue between the front end and the arithmetic back end.
module scta_queue import scta_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  item_t             push_item,
  input  logic              pop,
  output logic              q_valid,
  output item_t             head,
  output logic [QCNT_W-1:0] count
);

  item_t             slots [Q_DEPTH];
  logic [QIDX_W-1:0] wr_ptr;
  logic [QIDX_W-1:0] rd_ptr;

  assign q_valid = count != '0;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

[rtl/core/scta_map.sv]
`timescale 1ns / 1ps
// Span mapping: pipelined restoring divider per channel onto Q2.14 with saturation.
module scta_map import scta_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  item_t   in_item,
  output logic    out_valid,
  output mapped_t out_data
);

  typedef struct packed {
    logic [M_W-1:0]    rem;
    logic [Q_BITS-1:0] low;
    logic [Q_BITS-1:0] quo;
    logic [M_W-1:0]    div;
    logic              neg;
    logic              sat;
    logic              bad;
  } dstep_t;

  dstep_t s_st [Q_BITS+1];
  dstep_t c_st [Q_BITS+1];
  logic   vld  [Q_BITS+1];

  function automatic dstep_t load(input chan_t c);
    dstep_t n;
    n.rem = c.num[NUM_W-1:Q_BITS];
    n.low = c.num[Q_BITS-1:0];
    n.quo = '0;
    n.div = c.div;
    n.neg = c.neg;
    n.sat = c.sat;
    n.bad = c.bad;
    return n;
  endfunction

  function automatic dstep_t div_step(input dstep_t p);
    logic [M_W:0] trial;
    logic         ge;
    dstep_t       n;
    trial = {p.rem, p.low[Q_BITS-1]};
    ge    = trial >= {1'b0, p.div};
    n     = p;
    n.low = p.low << 1;
    n.rem = ge ? M_W'(trial - {1'b0, p.div}) : trial[M_W-1:0];
    n.quo = {p.quo[Q_BITS-2:0], ge};
    return n;
  endfunction

  function automatic logic signed [V_W-1:0] finish(input dstep_t p);
    logic signed [V_W+1:0] q;
    logic signed [V_W+1:0] v;
    logic signed [V_W-1:0] r;
    q = p.neg ? -$signed({2'b00, p.quo}) : $signed({2'b00, p.quo});
    v = q - (V_W + 2)'(ONE_Q14);
    if (p.bad) begin
      r = '0;
    end else if (p.sat) begin
      r = p.neg ? V_W'(V_MIN_I) : V_W'(V_MAX_I);
    end else if (v > (V_W + 2)'(V_MAX_I)) begin
      r = V_W'(V_MAX_I);
    end else if (v < (V_W + 2)'(V_MIN_I)) begin
      r = V_W'(V_MIN_I);
    end else begin
      r = v[V_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    s_st[0] <= load(in_item.sine);
    c_st[0] <= load(in_item.cosine);
  end

  for (genvar k = 0; k < Q_BITS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      s_st[k+1] <= div_step(s_st[k]);
      c_st[k+1] <= div_step(c_st[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[Q_BITS];
    end
    out_data.vs  <= finish(s_st[Q_BITS]);
    out_data.vc  <= finish(c_st[Q_BITS]);
    out_data.bad <= s_st[Q_BITS].bad || c_st[Q_BITS].bad;
  end

endmodule

[rtl/core/scta_solve.sv]
`timescale 1ns / 1ps
// Back end: magnitude by pipelined square root, angle by pipelined CORDIC, offset and wrap.
module scta_solve import scta_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  mapped_t                 in_data,
  input  logic signed [OFS_W-1:0] angle_offset,
  input  logic [TOL_W-1:0]        tolerance,
  output logic                    done,
  output logic [ANGLE_W-1:0]      angle_hundredths,
  output logic                    signal_fault,
  output logic [MAG_W-1:0]        magnitude_q14
);

  typedef struct packed {
    logic                  bad;
    logic                  zero;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic signed [ZW-1:0]  z;
    logic [RAD_W-1:0]      rad;
    logic [ROOT_W+1:0]     rem;
    logic [ROOT_W-1:0]     root;
  } step_t;

  logic                    v1;
  logic                    v2;
  logic signed [RAD_W-1:0] sq_s;
  logic signed [RAD_W-1:0] sq_c;
  step_t                   p1;
  step_t                   st  [NSTEP+1];
  logic                    vld [NSTEP+1];

  logic              e1_v, e2_v, e3_v;
  logic [WRAP_W-1:0] e1_w, e2_w, e3_w;
  logic              e1_f, e2_f, e3_f;
  logic [MAG_W-1:0]  e1_m, e2_m, e3_m;
  logic [WRAP_W-1:0] wrap_w;

  function automatic step_t prerotate(input mapped_t m);
    logic signed [V_W:0] xs;
    logic signed [V_W:0] ys;
    logic signed [V_W:0] x2;
    logic signed [V_W:0] y2;
    step_t               n;
    xs = (V_W + 1)'(m.vc);
    ys = (V_W + 1)'(m.vs);
    x2 = xs;
    y2 = ys;
    n  = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        x2  = ys;
        y2  = -xs;
        n.z = QUARTER_TURN;
      end else begin
        x2  = -ys;
        y2  = xs;
        n.z = -QUARTER_TURN;
      end
    end
    n.x    = $signed({{(CW - V_W - 1 - ANG_FRAC){x2[V_W]}}, x2, {ANG_FRAC{1'b0}}});
    n.y    = $signed({{(CW - V_W - 1 - ANG_FRAC){y2[V_W]}}, y2, {ANG_FRAC{1'b0}}});
    n.bad  = m.bad;
    n.zero = (m.vs == '0) && (m.vc == '0);
    return n;
  endfunction

  function automatic step_t iterate(input step_t p, input int i);
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic [ROOT_W+3:0]    trial;
    logic [ROOT_W+3:0]    tv;
    step_t                n;
    n     = p;
    xs    = p.x >>> i;
    ys    = p.y >>> i;
    trial = {p.rem, p.rad[RAD_W-1 -: 2]};
    tv    = {2'b00, p.root, 2'b01};
    if (i < CORDIC_STEPS) begin
      if (!p.y[CW-1]) begin
        n.x = p.x + ys;
        n.y = p.y - xs;
        n.z = p.z + ATAN_TABLE[i];
      end else begin
        n.x = p.x - ys;
        n.y = p.y + xs;
        n.z = p.z - ATAN_TABLE[i];
      end
    end
    if (i < ROOT_W) begin
      n.rad = p.rad << 2;
      if (trial >= tv) begin
        n.rem  = (ROOT_W + 2)'(trial - tv);
        n.root = {p.root[ROOT_W-2:0], 1'b1};
      end else begin
        n.rem  = trial[ROOT_W+1:0];
        n.root = {p.root[ROOT_W-2:0], 1'b0};
      end
    end
    return n;
  endfunction

  function automatic logic [WRAP_W-1:0] reduce(input logic [WRAP_W-1:0] w, input int k);
    return (w >= WRAP_W'(k)) ? w - WRAP_W'(k) : w;
  endfunction

  // square and prerotate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
    sq_s <= in_data.vs * in_data.vs;
    sq_c <= in_data.vc * in_data.vc;
    p1   <= prerotate(in_data);
  end

  always_comb begin
    st[0]      = p1;
    st[0].rad  = $unsigned(sq_s) + $unsigned(sq_c);
    st[0].rem  = '0;
    st[0].root = '0;
    vld[0]     = v1;
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        st[1] <= iterate(st[0], 0);
      end
      assign vld[1] = v2;
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i+1] <= 1'b0;
        end else begin
          vld[i+1] <= vld[i];
        end
        st[i+1] <= iterate(st[i], i);
      end
    end
  end

  // round, offset, bias into positive range; fault check
  always_ff @(posedge clk) begin : e1_blk
    logic signed [ZW-1:0]    zr;
    logic signed [ANG_W-1:0] ang;
    logic signed [WRAP_W:0]  total;
    logic [MAG_W-1:0]        dev;
    logic [ROOT_W-1:0]       r;
    r     = st[NSTEP].root;
    zr    = (st[NSTEP].z + ZW'(ROUND_HALF)) >>> ANG_FRAC;
    ang   = st[NSTEP].zero ? '0 : zr[ANG_W-1:0];
    total = (WRAP_W + 1)'(ang) + (WRAP_W + 1)'(angle_offset) + (WRAP_W + 1)'(WRAP_BIAS);
    dev   = (r >= MAG_W'(ONE_Q14)) ? r - MAG_W'(ONE_Q14) : MAG_W'(ONE_Q14) - r;
    if (rst) begin
      e1_v <= 1'b0;
    end else begin
      e1_v <= vld[NSTEP];
    end
    e1_w <= total[WRAP_W-1:0];
    e1_f <= st[NSTEP].bad || ({1'b0, dev} >= (MAG_W + 1)'(tolerance));
    e1_m <= st[NSTEP].bad ? '0 : r;
  end

  assign wrap_w = reduce(e3_w, FULL_TURN);

  always_ff @(posedge clk) begin
    if (rst) begin
      e2_v <= 1'b0;
      e3_v <= 1'b0;
      done <= 1'b0;
    end else begin
      e2_v <= e1_v;
      e3_v <= e2_v;
      done <= e3_v;
    end
    e2_w <= reduce(e1_w, 4 * FULL_TURN);
    e2_f <= e1_f;
    e2_m <= e1_m;
    e3_w <= reduce(e2_w, 2 * FULL_TURN);
    e3_f <= e2_f;
    e3_m <= e2_m;
    angle_hundredths <= wrap_w[ANGLE_W-1:0];
    signal_fault     <= e3_f;
    magnitude_q14    <= e3_m;
  end

endmodule

[rtl/core/sin_cos_sensor_to_angle_top.sv]
`timescale 1ns / 1ps
// Top level of the sine/cosine sensor to angle converter with its APB register file.
// Throughput: one sample pair per cycle while busy is low; the divider, square root and CORDIC are
// fully pipelined, one stage per quotient bit, root bit and micro-rotation.
// The result beat cannot be stalled; busy only guards the front-to-back queue.
// Reset is synchronous: pipeline and queue empty, registers at their defaults.
module sin_cos_sensor_to_angle_top import scta_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [SAMPLE_BITS-1:0] sine_sample,
  input  logic [SAMPLE_BITS-1:0] cosine_sample,
  output logic                   done,
  output logic [ANGLE_W-1:0]     angle_hundredths,
  output logic                   signal_fault,
  output logic [MAG_W-1:0]       magnitude_q14,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cfg_t              cfg;
  logic              push;
  item_t             push_item;
  logic              q_valid;
  item_t             head;
  logic [QCNT_W-1:0] q_count;
  logic              map_valid;
  mapped_t           map_data;
  logic [IDX_W-1:0]  idx;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sine_low     <= '0;
      cfg.sine_high    <= HIGH_RST;
      cfg.cosine_low   <= '0;
      cfg.cosine_high  <= HIGH_RST;
      cfg.angle_offset <= '0;
      cfg.tolerance    <= TOL_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_SINE_LOW:  cfg.sine_low     <= pwdata[SAMPLE_BITS-1:0];
        REG_SINE_HIGH: cfg.sine_high    <= pwdata[SAMPLE_BITS-1:0];
        REG_COS_LOW:   cfg.cosine_low   <= pwdata[SAMPLE_BITS-1:0];
        REG_COS_HIGH:  cfg.cosine_high  <= pwdata[SAMPLE_BITS-1:0];
        REG_OFFSET:    cfg.angle_offset <= pwdata[OFS_W-1:0];
        REG_TOLERANCE: cfg.tolerance    <= pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SINE_LOW:  prdata = 32'(cfg.sine_low);
      REG_SINE_HIGH: prdata = 32'(cfg.sine_high);
      REG_COS_LOW:   prdata = 32'(cfg.cosine_low);
      REG_COS_HIGH:  prdata = 32'(cfg.cosine_high);
      REG_OFFSET:    prdata = 32'(cfg.angle_offset);
      REG_TOLERANCE: prdata = 32'(cfg.tolerance);
      default:       prdata = '0;
    endcase
  end

  scta_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .sine_sample   (sine_sample),
    .cosine_sample (cosine_sample),
    .cfg           (cfg),
    .q_count       (q_count),
    .busy          (busy),
    .push          (push),
    .push_item     (push_item)
  );

  scta_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (q_valid),
    .q_valid   (q_valid),
    .head      (head),
    .count     (q_count)
  );

  scta_map u_map (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_item   (head),
    .out_valid (map_valid),
    .out_data  (map_data)
  );

  scta_solve u_solve (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (map_valid),
    .in_data          (map_data),
    .angle_offset     (cfg.angle_offset),
    .tolerance        (cfg.tolerance),
    .done             (done),
    .angle_hundredths (angle_hundredths),
    .signal_fault     (signal_fault),
    .magnitude_q14    (magnitude_q14)
  );

  // back end drains a beat every cycle, so the queue never backs up
  assert property (@(posedge clk) disable iff (rst) q_count <= QCNT_W'(1))
    else $error("queue holds more than one beat");
  assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("front end stalled");
  assert property (@(posedge clk) disable iff (rst)
                   done |-> angle_hundredths < ANGLE_W'(FULL_TURN))
    else $error("angle not wrapped");

endmodule
